// File: hw/rtl/cllh_pkg.sv
// Shared types, constants and field widths for the call latency log2 histogram.
// Used by every module of the block; depends on nothing.
package cllh_pkg;

    // Default sizes handed to the top level
    localparam int CPUS_DEF        = 8;
    localparam int SLOTS_DEF       = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths of the stream items
    localparam int OP_W         = 3;
    localparam int CPU_FIELD_W  = 3;
    localparam int TS_W         = 64;
    localparam int IDX_W        = 5;
    localparam int SLOT_FIELD_W = 5;
    localparam int SUM_W        = 64;
    localparam int COUNT_W      = 32;
    localparam int DIVISOR_W    = 32;
    localparam int LOG2_W       = 6;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 136;
    localparam int M_PAD_W   = M_TDATA_W - (TS_W + SLOT_FIELD_W + SUM_W);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CORE_FILTER = 2'd0,
        CFG_INCLUDE_ISR = 2'd1,
        CFG_BIN_DIVISOR = 2'd2
    } cfg_index_t;

    // Filter value that lets every CPU through
    localparam logic signed [3:0] FILTER_ALL = -4'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_CALL    = 3'd0,
        OP_IRQ     = 3'd1,
        OP_RET     = 3'd2,
        OP_RD_HIST = 3'd3,
        OP_RD_SUM  = 3'd4
    } op_t;

    // Command kinds after classification by the front end
    typedef enum logic [2:0] {
        CMD_NOP     = 3'd0,
        CMD_CALL    = 3'd1,
        CMD_IRQ     = 3'd2,
        CMD_RET     = 3'd3,
        CMD_RD_HIST = 3'd4,
        CMD_RD_SUM  = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [CPU_FIELD_W-1:0]  cpu;
        logic [TS_W-1:0]         ts;
        logic [IDX_W-1:0]        idx;
    } cmd_t;

    typedef struct packed {
        logic signed [3:0]       core_filter;
        logic                    include_isr;
        logic [DIVISOR_W-1:0]    bin_divisor;
    } cfg_t;

    typedef struct packed {
        logic                    start;
        logic [TS_W-1:0]         dividend;
        logic [DIVISOR_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [LOG2_W-1:0]       log2;
    } div_res_t;

    typedef enum logic [3:0] {
        B_IDLE    = 4'd0,
        B_LOOKUP  = 4'd1,
        B_ENTRY   = 4'd2,
        B_LATENCY = 4'd3,
        B_SUM     = 4'd4,
        B_DIV     = 4'd5,
        B_HIST_RD = 4'd6,
        B_HIST_WR = 4'd7,
        B_READ    = 4'd8,
        B_DONE    = 4'd9
    } back_state_t;

endpackage

// File: hw/rtl/cllh_front.sv
// Front end: configuration registers and classification of incoming items.
// Depends on cllh_pkg; feeds classified commands to the command queue.
module cllh_front #(
    parameter int CPUS = cllh_pkg::CPUS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cpu[2:0], timestamp[66:3], read_index[71:67]
    input  logic [cllh_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[2:0]
    input  logic [cllh_pkg::OP_W-1:0]         s_tuser,
    input  logic                              cfg_wr_en,
    input  logic [cllh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cllh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              q_full,
    output logic                              q_push,
    output cllh_pkg::cmd_t                    q_cmd,
    output cllh_pkg::cfg_t                    cfg
);

    cllh_pkg::cfg_t cfg_reg;
    cllh_pkg::cfg_t cfg_next;

    logic [cllh_pkg::CPU_FIELD_W-1:0] s_cpu;
    logic [cllh_pkg::TS_W-1:0]        s_ts;
    logic [cllh_pkg::IDX_W-1:0]       s_idx;
    logic                             cpu_ok;
    logic                             entry_ok;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                cllh_pkg::CFG_CORE_FILTER: cfg_next.core_filter = cfg_wdata[3:0];
                cllh_pkg::CFG_INCLUDE_ISR: cfg_next.include_isr = cfg_wdata[0];
                cllh_pkg::CFG_BIN_DIVISOR: cfg_next.bin_divisor = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{core_filter: cllh_pkg::FILTER_ALL, include_isr: 1'b0,
                         bin_divisor: 32'd1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // Unpack the item
    assign s_cpu = s_tdata[2:0];
    assign s_ts  = s_tdata[66:3];
    assign s_idx = s_tdata[71:67];

    // CPU range and core filter; a negative filter other than all matches nothing
    assign cpu_ok   = 32'(s_cpu) < CPUS;
    assign entry_ok = (cfg_reg.core_filter == cllh_pkg::FILTER_ALL) ||
                      (!cfg_reg.core_filter[3] && (cfg_reg.core_filter[2:0] == s_cpu));

    // Classify
    always_comb begin
        q_cmd.cpu = s_cpu;
        q_cmd.ts  = s_ts;
        q_cmd.idx = s_idx;
        case (cllh_pkg::op_t'(s_tuser))
            cllh_pkg::OP_CALL:
                q_cmd.kind = (cpu_ok && entry_ok) ? cllh_pkg::CMD_CALL : cllh_pkg::CMD_NOP;
            cllh_pkg::OP_IRQ:
                q_cmd.kind = (cpu_ok && entry_ok) ? cllh_pkg::CMD_IRQ : cllh_pkg::CMD_NOP;
            cllh_pkg::OP_RET:
                q_cmd.kind = cpu_ok ? cllh_pkg::CMD_RET : cllh_pkg::CMD_NOP;
            cllh_pkg::OP_RD_HIST: q_cmd.kind = cllh_pkg::CMD_RD_HIST;
            cllh_pkg::OP_RD_SUM:  q_cmd.kind = cllh_pkg::CMD_RD_SUM;
            default:              q_cmd.kind = cllh_pkg::CMD_NOP;
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// File: hw/rtl/cllh_fifo.sv
// Short command queue between the front end and the back end.
// Depends on cllh_pkg for the command type.
module cllh_fifo #(
    parameter int DEPTH = cllh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cllh_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output cllh_pkg::cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cllh_pkg::cmd_t q_mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = q_mem[rd_ptr_reg];

endmodule

// File: hw/rtl/cllh_div.sv
// Serial restoring divider, one quotient bit a cycle, reporting floor log2
// of the quotient. Depends on cllh_pkg for the request and result types.
module cllh_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  cllh_pkg::div_req_t div_req,
    output cllh_pkg::div_res_t div_res
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [cllh_pkg::LOG2_W-1:0]       cnt_reg;
    logic [cllh_pkg::TS_W-1:0]         dvd_reg;
    logic [cllh_pkg::DIVISOR_W-1:0]    dsr_reg;
    logic [cllh_pkg::DIVISOR_W-1:0]    rem_reg;
    logic                              found_reg;
    logic [cllh_pkg::LOG2_W-1:0]       log2_reg;

    logic [cllh_pkg::DIVISOR_W:0]      rem_sh;
    logic                              fits;
    logic [cllh_pkg::DIVISOR_W-1:0]    rem_new;

    // One step: shift in the next dividend bit, subtract when it fits.
    // A zero divisor never fits, so the quotient reads as zero.
    assign rem_sh  = {rem_reg, dvd_reg[cllh_pkg::TS_W-1]};
    assign fits    = (dsr_reg != '0) && (rem_sh >= {1'b0, dsr_reg});
    assign rem_new = fits ? cllh_pkg::DIVISOR_W'(rem_sh - {1'b0, dsr_reg})
                          : rem_sh[cllh_pkg::DIVISOR_W-1:0];

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath; first quotient bit found gives floor log2
    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            cnt_reg   <= '1;
            dvd_reg   <= div_req.dividend;
            dsr_reg   <= div_req.divisor;
            rem_reg   <= '0;
            found_reg <= 1'b0;
            log2_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            dvd_reg <= {dvd_reg[cllh_pkg::TS_W-2:0], 1'b0};
            rem_reg <= rem_new;
            if (fits && !found_reg) begin
                found_reg <= 1'b1;
                log2_reg  <= cnt_reg;
            end
        end
    end

    assign div_res = '{done: done_reg, log2: log2_reg};

endmodule

// File: hw/rtl/cllh_back.sv
// Back end: sequencer that executes commands against the per-CPU stores,
// sums and histogram, and the output register. Depends on cllh_pkg.
module cllh_back #(
    parameter int CPUS  = cllh_pkg::CPUS_DEF,
    parameter int SLOTS = cllh_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  cllh_pkg::cmd_t                 q_head,
    output logic                           q_pop,
    input  cllh_pkg::cfg_t                 cfg,
    output cllh_pkg::div_req_t             div_req,
    input  cllh_pkg::div_res_t             div_res,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // latency[63:0], slot[68:64], read_value[132:69], zero[135:133]
    output logic [cllh_pkg::M_TDATA_W-1:0] m_tdata,
    // recorded[0]
    output logic [0:0]                     m_tuser
);

    localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);

    cllh_pkg::back_state_t state_reg, state_next;
    cllh_pkg::cmd_t        cmd_reg;

    // Result under construction
    logic                            rec_reg;
    logic [cllh_pkg::TS_W-1:0]       lat_reg;
    logic [SLOT_W-1:0]               slot_reg;
    logic [cllh_pkg::SUM_W-1:0]      rval_reg;
    logic [SLOT_W-1:0]               hist_addr_reg;
    logic [CPU_W-1:0]                sum_addr_reg;

    // Control state and valid bits
    logic [cllh_pkg::SUM_W-1:0]      global_sum_reg;
    logic [CPUS-1:0]                 active_reg;
    logic [CPUS-1:0]                 irq_seen_reg;
    logic [CPUS-1:0]                 sum_vld_reg;
    logic [SLOTS-1:0]                hist_vld_reg;

    // Output register
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            m_rec_reg;
    logic [cllh_pkg::TS_W-1:0]       m_lat_reg;
    logic [SLOT_W-1:0]               m_slot_reg;
    logic [cllh_pkg::SUM_W-1:0]      m_rval_reg;

    // Stores
    logic [cllh_pkg::TS_W-1:0]       start_mem [CPUS];
    logic [cllh_pkg::TS_W-1:0]       irq_mem   [CPUS];
    logic [cllh_pkg::SUM_W-1:0]      sum_mem   [CPUS];
    logic [cllh_pkg::COUNT_W-1:0]    hist_mem  [SLOTS];
    logic [cllh_pkg::TS_W-1:0]       start_rd_reg;
    logic [cllh_pkg::TS_W-1:0]       irq_rd_reg;
    logic [cllh_pkg::SUM_W-1:0]      sum_rd_reg;
    logic [cllh_pkg::COUNT_W-1:0]    hist_rd_reg;

    // Strobes
    logic call_we, irq_we, lat_ld, sum_we, slot_ld, hist_we, read_ld, out_ld;

    logic [CPU_W-1:0]                cpu_idx;
    logic                            out_free;
    logic [cllh_pkg::TS_W-1:0]       lat_calc;
    logic [cllh_pkg::SUM_W-1:0]      sum_old;
    logic [cllh_pkg::COUNT_W-1:0]    hist_old;
    logic [SLOT_W-1:0]               slot_calc;
    logic [cllh_pkg::SUM_W-1:0]      read_value;

    assign cpu_idx  = CPU_W'(cmd_reg.cpu);
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cllh_pkg::B_IDLE: begin
                if (q_valid) begin
                    case (q_head.kind)
                        cllh_pkg::CMD_CALL, cllh_pkg::CMD_IRQ:
                            state_next = cllh_pkg::B_ENTRY;
                        cllh_pkg::CMD_RET, cllh_pkg::CMD_RD_HIST, cllh_pkg::CMD_RD_SUM:
                            state_next = cllh_pkg::B_LOOKUP;
                        default:
                            state_next = cllh_pkg::B_DONE;
                    endcase
                end
            end
            cllh_pkg::B_LOOKUP: begin
                if (cmd_reg.kind == cllh_pkg::CMD_RET) begin
                    state_next = active_reg[cpu_idx] ? cllh_pkg::B_LATENCY : cllh_pkg::B_DONE;
                end else begin
                    state_next = cllh_pkg::B_READ;
                end
            end
            cllh_pkg::B_ENTRY:   state_next = cllh_pkg::B_DONE;
            cllh_pkg::B_LATENCY: state_next = cllh_pkg::B_SUM;
            cllh_pkg::B_SUM:     state_next = cllh_pkg::B_DIV;
            cllh_pkg::B_DIV: begin
                if (div_res.done) begin
                    state_next = cllh_pkg::B_HIST_RD;
                end
            end
            cllh_pkg::B_HIST_RD: state_next = cllh_pkg::B_HIST_WR;
            cllh_pkg::B_HIST_WR: state_next = cllh_pkg::B_DONE;
            cllh_pkg::B_READ:    state_next = cllh_pkg::B_DONE;
            cllh_pkg::B_DONE: begin
                if (out_free) begin
                    state_next = cllh_pkg::B_IDLE;
                end
            end
            default: state_next = cllh_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        q_pop   = 1'b0;
        call_we = 1'b0;
        irq_we  = 1'b0;
        lat_ld  = 1'b0;
        sum_we  = 1'b0;
        slot_ld = 1'b0;
        hist_we = 1'b0;
        read_ld = 1'b0;
        out_ld  = 1'b0;
        case (state_reg)
            cllh_pkg::B_IDLE:    q_pop   = q_valid;
            cllh_pkg::B_ENTRY: begin
                call_we = (cmd_reg.kind == cllh_pkg::CMD_CALL);
                irq_we  = (cmd_reg.kind == cllh_pkg::CMD_IRQ);
            end
            cllh_pkg::B_LATENCY: lat_ld  = 1'b1;
            cllh_pkg::B_SUM:     sum_we  = 1'b1;
            cllh_pkg::B_DIV:     slot_ld = div_res.done;
            cllh_pkg::B_HIST_WR: hist_we = 1'b1;
            cllh_pkg::B_READ:    read_ld = 1'b1;
            cllh_pkg::B_DONE:    out_ld  = out_free;
            default: ;
        endcase
    end

    // Latency ends at the interrupt unless interrupt time is included
    assign lat_calc = ((irq_seen_reg[cpu_idx] && !cfg.include_isr) ? irq_rd_reg : cmd_reg.ts)
                      - start_rd_reg;

    assign sum_old  = sum_vld_reg[sum_addr_reg]   ? sum_rd_reg  : '0;
    assign hist_old = hist_vld_reg[hist_addr_reg] ? hist_rd_reg : '0;

    // Clamp the log2 to the last slot
    assign slot_calc = (32'(div_res.log2) >= SLOTS) ? SLOT_W'(SLOTS - 1)
                                                    : SLOT_W'(div_res.log2);

    // Read results; out of range reads give zero
    always_comb begin
        read_value = '0;
        if (cmd_reg.kind == cllh_pkg::CMD_RD_HIST) begin
            if (32'(cmd_reg.idx) < SLOTS) begin
                read_value = cllh_pkg::SUM_W'(hist_old);
            end
        end else if (cmd_reg.idx == '0) begin
            read_value = global_sum_reg;
        end else if (32'(cmd_reg.idx) <= CPUS) begin
            read_value = sum_old;
        end
    end

    assign div_req = '{start: sum_we, dividend: lat_reg, divisor: cfg.bin_divisor};

    assign m_tvalid_next = out_ld ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    // Control registers and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cllh_pkg::B_IDLE;
            m_tvalid_reg   <= 1'b0;
            global_sum_reg <= '0;
            active_reg     <= '0;
            irq_seen_reg   <= '0;
            sum_vld_reg    <= '0;
            hist_vld_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (call_we) begin
                active_reg[cpu_idx]   <= 1'b1;
                irq_seen_reg[cpu_idx] <= 1'b0;
            end
            if (irq_we) begin
                irq_seen_reg[cpu_idx] <= 1'b1;
            end
            if (lat_ld) begin
                active_reg[cpu_idx] <= 1'b0;
            end
            if (sum_we) begin
                global_sum_reg            <= global_sum_reg + lat_reg;
                sum_vld_reg[sum_addr_reg] <= 1'b1;
            end
            if (hist_we) begin
                hist_vld_reg[hist_addr_reg] <= 1'b1;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg       <= q_head;
            rec_reg       <= 1'b0;
            lat_reg       <= '0;
            slot_reg      <= '0;
            rval_reg      <= '0;
            hist_addr_reg <= SLOT_W'(q_head.idx);
            sum_addr_reg  <= (q_head.kind == cllh_pkg::CMD_RD_SUM)
                             ? CPU_W'(q_head.idx - 5'd1) : CPU_W'(q_head.cpu);
        end
        if (lat_ld) begin
            lat_reg <= lat_calc;
        end
        if (slot_ld) begin
            rec_reg       <= 1'b1;
            slot_reg      <= slot_calc;
            hist_addr_reg <= slot_calc;
        end
        if (read_ld) begin
            rval_reg <= read_value;
        end
        if (out_ld) begin
            m_rec_reg  <= rec_reg;
            m_lat_reg  <= lat_reg;
            m_slot_reg <= slot_reg;
            m_rval_reg <= rval_reg;
        end
    end

    // Call start times
    always_ff @(posedge aclk) begin
        if (call_we) begin
            start_mem[cpu_idx] <= cmd_reg.ts;
        end
        start_rd_reg <= start_mem[cpu_idx];
    end

    // Interrupt times
    always_ff @(posedge aclk) begin
        if (irq_we) begin
            irq_mem[cpu_idx] <= cmd_reg.ts;
        end
        irq_rd_reg <= irq_mem[cpu_idx];
    end

    // Per-CPU latency sums
    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_addr_reg] <= sum_old + lat_reg;
        end
        sum_rd_reg <= sum_mem[sum_addr_reg];
    end

    // Histogram counters, wrapping
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_addr_reg] <= hist_old + 32'd1;
        end
        hist_rd_reg <= hist_mem[hist_addr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_rec_reg;
    assign m_tdata  = {{cllh_pkg::M_PAD_W{1'b0}}, m_rval_reg,
                       cllh_pkg::SLOT_FIELD_W'(m_slot_reg), m_lat_reg};

endmodule

// File: hw/rtl/call_latency_log2_histogram_top.sv
// Per-CPU call latency log2 histogram: command flow, interfaces and sizing.
// Depends on cllh_pkg, cllh_front, cllh_fifo, cllh_div and cllh_back.
//
// Events arrive on the s_ stream (operation in tuser; cpu, timestamp and read
// index in tdata) and every accepted item yields exactly one result on the m_
// stream. A front end classifies items into a short command queue, so input
// is taken while the back end works; the back end handles one command at a
// time. A call return that records a sample pops the command, looks up the
// start time, forms the latency and updates the sums, then waits on the serial
// divider (64 quotient bits, one per cycle, which also yield floor log2 of the
// quotient, then its done flag), does a read-modify-write of the histogram
// counter and loads the output register. Call and interrupt entries record
// their timestamp and, like ignored events and returns without a start, give
// a result with no sample; reads return the value asked for. A result held
// by m_tready low stalls the back end until it is taken.
// All stores come out of reset empty through valid bits; there is no clearing
// pass. Configuration is to be written through cfg_wr_en/cfg_index/cfg_wdata
// while no item is in flight; the block itself does not enforce this.
module call_latency_log2_histogram_top #(
    parameter int CPUS        = cllh_pkg::CPUS_DEF,
    parameter int SLOTS       = cllh_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = cllh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cpu[2:0], timestamp[66:3], read_index[71:67]
    input  logic [cllh_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[2:0]
    input  logic [cllh_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // latency[63:0], slot[68:64], read_value[132:69], zero[135:133]
    output logic [cllh_pkg::M_TDATA_W-1:0]    m_tdata,
    // recorded[0]
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [cllh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cllh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    cllh_pkg::cmd_t     push_cmd;
    cllh_pkg::cmd_t     head_cmd;
    cllh_pkg::cfg_t     cfg;
    cllh_pkg::div_req_t div_req;
    cllh_pkg::div_res_t div_res;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;

    // Classification and configuration
    cllh_front #(
        .CPUS (CPUS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cfg       (cfg)
    );

    // Command queue
    cllh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    // Serial divider for binning
    cllh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_res (div_res)
    );

    // Execution and output register
    cllh_back #(
        .CPUS  (CPUS),
        .SLOTS (SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .div_req  (div_req),
        .div_res  (div_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for call_latency_log2_histogram_top: a directed table, then random
// call/interrupt/return runs, reads and noise, checked against a latency tracker or the table.
// Depends on cllh_pkg and the RTL of the block.
module tb_top;
    import cllh_pkg::*;

    localparam int CPUS        = CPUS_DEF;
    localparam int SLOTS       = SLOTS_DEF;
    localparam int RAND_ITEMS  = 825;
    localparam int CFG_EVERY   = 110;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_SHOWN   = 10;

    // Operation codes the block does not define
    localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;
    // Negative filter other than all-CPUs: matches nothing
    localparam logic signed [3:0] FILTER_NONE = -4'sd8;
    localparam logic [TS_W-1:0]   TS_MAX      = '1;

    typedef struct packed {
        logic                    recorded;
        logic [TS_W-1:0]         latency;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [SUM_W-1:0]        read_value;
    } latency_report_t;

    typedef struct packed {
        logic            typed;
        latency_report_t want;
    } report_tag_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [OP_W-1:0]         op;
        logic [CPU_FIELD_W-1:0]  cpu;
        logic [TS_W-1:0]         ts;
        logic [IDX_W-1:0]        idx;
        logic                    typed;
        latency_report_t         want;
        cfg_index_t              reg_sel;
        logic [CFG_DATA_W-1:0]   reg_val;
    } stim_row_t;

    localparam latency_report_t NO_SAMPLE = '0;
    localparam latency_report_t CLAMPED_MAX = {1'b1, TS_MAX, 5'(SLOTS - 1), 64'd0};

    // DUT connections, every input driven to a known value from time zero
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Tracker copy of the block's state and registers
    logic [TS_W-1:0]       entry_ts    [CPUS];
    logic                  in_call     [CPUS];
    logic [TS_W-1:0]       irq_ts      [CPUS];
    logic                  irq_pending [CPUS];
    logic [SUM_W-1:0]      sum_ns      [CPUS+1];
    logic [COUNT_W-1:0]    bin_count   [SLOTS];
    logic signed [3:0]     flt_cpu    = FILTER_ALL;
    logic                  isr_incl   = 1'b0;
    logic [DIVISOR_W-1:0]  div_factor = 32'd1;

    latency_report_t latency_reports[$];
    report_tag_t     typed_reports[$];
    int              report_mismatches = 0;
    int              sent = 0;
    int              send_idle = 22;
    int              recv_idle = 62;
    logic [TS_W-1:0] cpu_clock [CPUS];

    // Monitor scratch
    report_tag_t     tag_now;
    latency_report_t owed;
    latency_report_t seen;

    call_latency_log2_histogram_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Entry events pass when the filter is all-CPUs or names this CPU
    function automatic logic entry_ok(logic [CPU_FIELD_W-1:0] cpu);
        return (flt_cpu == FILTER_ALL) || (!flt_cpu[3] && flt_cpu[2:0] == cpu);
    endfunction

    // Applies one item to the tracker and returns the result it must produce
    function automatic latency_report_t track_call_latency(logic [OP_W-1:0] op,
            logic [CPU_FIELD_W-1:0] cpu, logic [TS_W-1:0] ts, logic [IDX_W-1:0] idx);
        latency_report_t rep;
        logic [TS_W-1:0] lat;
        logic [TS_W-1:0] quot;
        int              lg;
        rep = '0;
        case (op)
            OP_CALL: begin
                if (entry_ok(cpu)) begin
                    irq_pending[cpu] = 1'b0;
                    entry_ts[cpu]    = ts;
                    in_call[cpu]     = 1'b1;
                end
            end
            OP_IRQ: begin
                if (entry_ok(cpu)) begin
                    irq_ts[cpu]      = ts;
                    irq_pending[cpu] = 1'b1;
                end
            end
            OP_RET: begin
                if (in_call[cpu]) begin
                    // without ISR time the sample stops at the interrupt
                    if (irq_pending[cpu] && !isr_incl)
                        lat = irq_ts[cpu] - entry_ts[cpu];
                    else
                        lat = ts - entry_ts[cpu];
                    in_call[cpu] = 1'b0;
                    sum_ns[0] += lat;
                    sum_ns[int'(cpu) + 1] += lat;
                    quot = (div_factor != 0) ? lat / {32'd0, div_factor} : '0;
                    lg = 0;
                    for (int b = 0; b < TS_W; b++)
                        if (quot[b]) lg = b;
                    if (lg > SLOTS - 1)
                        lg = SLOTS - 1;
                    bin_count[lg] += 1;
                    rep.recorded = 1'b1;
                    rep.latency  = lat;
                    rep.slot     = 5'(lg);
                end
            end
            OP_RD_HIST: begin
                if (idx < SLOTS)
                    rep.read_value = {32'd0, bin_count[idx]};
            end
            OP_RD_SUM: begin
                if (idx <= CPUS)
                    rep.read_value = sum_ns[idx];
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Receiver: random back-pressure by phase
    always @(posedge aclk) begin
        m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    // Track accepted items and check accepted results against the oldest owed one
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tag_now = typed_reports.pop_front();
                owed = track_call_latency(s_tuser, s_tdata[2:0], s_tdata[66:3], s_tdata[71:67]);
                latency_reports.push_back(tag_now.typed ? tag_now.want : owed);
            end
            if (m_tvalid && m_tready) begin
                seen.recorded   = m_tuser[0];
                seen.latency    = m_tdata[63:0];
                seen.slot       = m_tdata[68:64];
                seen.read_value = m_tdata[132:69];
                if (latency_reports.size() == 0) begin
                    report_mismatches++;
                    if (report_mismatches <= MAX_SHOWN)
                        $display("unexpected result: rec=%0d lat=%0h slot=%0d val=%0h",
                                 seen.recorded, seen.latency, seen.slot, seen.read_value);
                end else begin
                    owed = latency_reports.pop_front();
                    if (seen.recorded !== owed.recorded || seen.latency !== owed.latency ||
                        seen.slot !== owed.slot || seen.read_value !== owed.read_value) begin
                        report_mismatches++;
                        if (report_mismatches <= MAX_SHOWN) begin
                            $display("mismatch: exp rec=%0d lat=%0h slot=%0d val=%0h",
                                     owed.recorded, owed.latency, owed.slot, owed.read_value);
                            $display("          got rec=%0d lat=%0h slot=%0d val=%0h",
                                     seen.recorded, seen.latency, seen.slot, seen.read_value);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one item after a random gap and holds it until accepted
    task automatic drive_item(logic [OP_W-1:0] op, logic [CPU_FIELD_W-1:0] cpu,
            logic [TS_W-1:0] ts, logic [IDX_W-1:0] idx, logic typed, latency_report_t want);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        typed_reports.push_back({typed, want});
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {idx, ts, cpu};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Holds off the sender until every owed result has come back
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (latency_reports.size() != 0);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(cfg_index_t sel, logic [CFG_DATA_W-1:0] val);
        drain_reports();
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge aclk);
        case (sel)
            CFG_CORE_FILTER: flt_cpu    = val[3:0];
            CFG_INCLUDE_ISR: isr_incl   = val[0];
            CFG_BIN_DIVISOR: div_factor = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_random_config();
        logic [3:0]           flt;
        logic [DIVISOR_W-1:0] dv;
        flt = ($urandom_range(1) == 0) ? FILTER_ALL : 4'($urandom_range(15));
        case ($urandom_range(3))
            0:       dv = 32'd1;
            1:       dv = '1;
            2:       dv = 32'($urandom_range(64, 1));
            default: dv = $urandom;
        endcase
        write_reg(CFG_CORE_FILTER, {28'd0, flt});
        write_reg(CFG_INCLUDE_ISR, 32'($urandom_range(1)));
        write_reg(CFG_BIN_DIVISOR, dv);
    endtask

    // Gaps of very different sizes so that every slot gets used
    function automatic logic [TS_W-1:0] rand_gap();
        case ($urandom_range(3))
            0:       return 64'($urandom_range(15));
            1:       return 64'($urandom_range(100000));
            2:       return {$urandom, $urandom} >> $urandom_range(63);
            default: return 64'($urandom);
        endcase
    endfunction

    task automatic send_read();
        if ($urandom_range(1) == 0)
            drive_item(OP_RD_HIST, 3'($urandom), {$urandom, $urandom}, 5'($urandom), 1'b0,
                       NO_SAMPLE);
        else
            drive_item(OP_RD_SUM, 3'($urandom), {$urandom, $urandom},
                       5'(($urandom_range(99) < 70) ? $urandom_range(CPUS) : $urandom_range(31)),
                       1'b0, NO_SAMPLE);
    endtask

    // Well-formed call: entry, maybe an interrupt and a read, then the return
    task automatic send_call_run(logic [CPU_FIELD_W-1:0] cpu);
        logic [TS_W-1:0] t0;
        logic [TS_W-1:0] t1;
        t0 = cpu_clock[cpu] + rand_gap();
        drive_item(OP_CALL, cpu, t0, 5'($urandom), 1'b0, NO_SAMPLE);
        if ($urandom_range(1) == 1)
            drive_item(OP_IRQ, cpu, t0 + rand_gap(), 5'($urandom), 1'b0, NO_SAMPLE);
        if ($urandom_range(4) == 0)
            send_read();
        t1 = t0 + rand_gap();
        drive_item(OP_RET, cpu, t1, 5'($urandom), 1'b0, NO_SAMPLE);
        cpu_clock[cpu] = t1;
    endtask

    function automatic stim_row_t row_evt(logic [OP_W-1:0] op, logic [CPU_FIELD_W-1:0] cpu,
            logic [TS_W-1:0] ts, logic [IDX_W-1:0] idx);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.op   = op;
        row.cpu  = cpu;
        row.ts   = ts;
        row.idx  = idx;
        return row;
    endfunction

    function automatic stim_row_t row_fix(logic [OP_W-1:0] op, logic [CPU_FIELD_W-1:0] cpu,
            logic [TS_W-1:0] ts, logic [IDX_W-1:0] idx, latency_report_t want);
        stim_row_t row;
        row       = row_evt(op, cpu, ts, idx);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t row_reg(cfg_index_t sel, logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    // Stimulus sequencing
    initial begin
        stim_row_t              dir_rows[$];
        int                     base;
        int                     next_cfg;
        int                     pick;
        logic [CPU_FIELD_W-1:0] cpu;

        for (int i = 0; i < CPUS; i++) begin
            entry_ts[i]    = '0;
            in_call[i]     = 1'b0;
            irq_ts[i]      = '0;
            irq_pending[i] = 1'b0;
            cpu_clock[i]   = '0;
        end
        for (int i = 0; i <= CPUS; i++)
            sum_ns[i] = '0;
        for (int i = 0; i < SLOTS; i++)
            bin_count[i] = '0;

        // Directed table: empty stores, extremes, filter and ISR modes, divisor corners
        dir_rows.push_back(row_fix(OP_RD_HIST, 3'd0, '0, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_RD_SUM, 3'd0, '0, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_RET, 3'd3, 64'd500, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_BAD_LO, 3'd1, 64'd7, 5'd1, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_BAD_HI, 3'd7, TS_MAX, 5'd31, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_CALL, 3'd0, '0, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_RET, 3'd0, TS_MAX, 5'd0, CLAMPED_MAX));
        dir_rows.push_back(row_fix(OP_CALL, 3'd7, TS_MAX, 5'd31, NO_SAMPLE));
        dir_rows.push_back(row_evt(OP_RET, 3'd7, '0, 5'd0));
        dir_rows.push_back(row_fix(OP_CALL, 3'd2, 64'd100, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_IRQ, 3'd2, 64'd150, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_evt(OP_RET, 3'd2, 64'd1000, 5'd0));
        dir_rows.push_back(row_fix(OP_RD_SUM, 3'd0, '0, 5'(CPUS + 1), NO_SAMPLE));
        dir_rows.push_back(row_evt(OP_RD_SUM, 3'd0, '0, 5'd3));
        dir_rows.push_back(row_evt(OP_RD_HIST, 3'd0, '0, 5'd31));
        // single-CPU filter, ISR time included, zero divisor
        dir_rows.push_back(row_reg(CFG_CORE_FILTER, 32'd7));
        dir_rows.push_back(row_reg(CFG_INCLUDE_ISR, 32'd1));
        dir_rows.push_back(row_reg(CFG_BIN_DIVISOR, 32'd0));
        dir_rows.push_back(row_fix(OP_CALL, 3'd1, 64'd10, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_RET, 3'd1, 64'd20, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_CALL, 3'd7, 64'd10, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_IRQ, 3'd7, 64'd15, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_evt(OP_RET, 3'd7, 64'd1000000, 5'd0));
        // filter that matches no CPU, largest divisor
        dir_rows.push_back(row_reg(CFG_CORE_FILTER, {28'd0, FILTER_NONE}));
        dir_rows.push_back(row_reg(CFG_INCLUDE_ISR, 32'd0));
        dir_rows.push_back(row_reg(CFG_BIN_DIVISOR, '1));
        dir_rows.push_back(row_fix(OP_CALL, 3'd5, '0, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_fix(OP_RET, 3'd5, TS_MAX, 5'd0, NO_SAMPLE));
        // back to all CPUs; interrupt mark left over from an earlier return
        dir_rows.push_back(row_reg(CFG_CORE_FILTER, {28'd0, FILTER_ALL}));
        dir_rows.push_back(row_reg(CFG_BIN_DIVISOR, 32'd3));
        dir_rows.push_back(row_fix(OP_IRQ, 3'd2, 64'd5000, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_evt(OP_RET, 3'd2, 64'd9000, 5'd0));
        dir_rows.push_back(row_fix(OP_CALL, 3'd6, 64'd7, 5'd0, NO_SAMPLE));
        dir_rows.push_back(row_evt(OP_RET, 3'd6, TS_MAX, 5'd0));
        dir_rows.push_back(row_evt(OP_RD_SUM, 3'd0, '0, 5'd0));
        dir_rows.push_back(row_evt(OP_RD_HIST, 3'd0, '0, 5'd0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                drive_item(dir_rows[i].op, dir_rows[i].cpu, dir_rows[i].ts, dir_rows[i].idx,
                           dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part: mostly well-formed calls, some reads, some noise
        base     = sent;
        next_cfg = sent;
        while (sent < base + RAND_ITEMS) begin
            if (sent - base < RAND_ITEMS / 3) begin
                send_idle = 22;
                recv_idle = 62;
            end else if (sent - base < 2 * RAND_ITEMS / 3) begin
                send_idle = 62;
                recv_idle = 22;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (sent >= next_cfg) begin
                apply_random_config();
                next_cfg = sent + CFG_EVERY;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                if (!flt_cpu[3] && $urandom_range(99) < 70)
                    cpu = flt_cpu[2:0];
                else
                    cpu = 3'($urandom_range(CPUS - 1));
                send_call_run(cpu);
            end else if (pick < 80) begin
                send_read();
            end else begin
                drive_item(3'($urandom_range(OP_BAD_HI)), 3'($urandom), {$urandom, $urandom},
                           5'($urandom), 1'b0, NO_SAMPLE);
            end
        end

        // Wind down: every result back, then a quiet tail for stray outputs
        drain_reports();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (report_mismatches == 0 && latency_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
